>>> hdl/gfsr_pkg.sv
`timescale 1ns / 1ps

package gfsr_pkg;

   localparam int RING_DEPTH = 624;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int SUM_W      = ADDR_W + 1;
   localparam int WORD_W     = 32;
   localparam int OFF_W      = 10;
   localparam int SHIFT_W    = 5;
   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int WORDS_WIDE = 4;

   localparam logic [WORD_W-1:0] SEED_MULT = 32'd31415;

   // reciprocal division of a ten-bit value by the ring depth
   localparam int MOD_SHIFT = 20;
   localparam int PROD_W    = MOD_SHIFT + OFF_W;
   localparam int RECIP     = (1 << MOD_SHIFT) / RING_DEPTH + 1;

   localparam logic [KIND_W-1:0] KIND_SEED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FOUR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LAG_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_SHIFT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_SHIFT  = 3'd4;

   typedef struct packed {
      logic [SHIFT_W-1:0] feedback_shift;
      logic [SHIFT_W-1:0] output_shift;
      logic [SHIFT_W-1:0] right_shift_amount;
      logic [SHIFT_W-1:0] left_shift_amount;
   } shift_cfg_type;

   // quotient of x by the ring depth, exact for every ten-bit x
   function automatic logic [OFF_W-1:0] quot_ring(input logic [OFF_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP);
      return prod[MOD_SHIFT +: OFF_W];
   endfunction

   // remainder once the quotient is known
   function automatic logic [ADDR_W-1:0] rem_ring(input logic [OFF_W-1:0] x,
                                                  input logic [OFF_W-1:0] q);
      logic [PROD_W-1:0] r;
      r = PROD_W'(x) - PROD_W'(q) * PROD_W'(RING_DEPTH);
      return r[ADDR_W-1:0];
   endfunction

   // sum of two ring indexes, both below the depth
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SUM_W'(RING_DEPTH)) begin
         s = s - SUM_W'(RING_DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

>>> hdl/gfsr_if.sv
`timescale 1ns / 1ps

interface gfsr_req_if;
   logic                             valid;
   logic                             ready;
   logic [gfsr_pkg::KIND_W-1:0]      kind;
   logic [gfsr_pkg::WORD_W-1:0]      seed_value;
   logic [gfsr_pkg::OFF_W-1:0]       read_offset;
   modport source (output valid, kind, seed_value, read_offset, input ready);
   modport sink   (input valid, kind, seed_value, read_offset, output ready);
endinterface

interface gfsr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [gfsr_pkg::WORD_W-1:0]      word0;
   logic [gfsr_pkg::WORD_W-1:0]      word1;
   logic [gfsr_pkg::WORD_W-1:0]      word2;
   logic [gfsr_pkg::WORD_W-1:0]      word3;
   logic [gfsr_pkg::COUNT_W-1:0]     word_count;
   modport source (output valid, word0, word1, word2, word3, word_count, input ready);
   modport sink   (input valid, word0, word1, word2, word3, word_count, output ready);
endinterface

interface gfsr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gfsr_pkg::CSR_IDX_W-1:0]   index;
   logic [gfsr_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/gfsr_mix.sv
`timescale 1ns / 1ps

module gfsr_mix (
   input  logic [gfsr_pkg::WORD_W-1:0] cur_word,
   input  logic [gfsr_pkg::WORD_W-1:0] lag_word,
   input  logic [gfsr_pkg::WORD_W-1:0] lung_word,
   input  gfsr_pkg::shift_cfg_type     shift_cfg,
   output logic [gfsr_pkg::WORD_W-1:0] entry_word,
   output logic [gfsr_pkg::WORD_W-1:0] mix_word
);

   logic [gfsr_pkg::WORD_W-1:0] base_word;

   assign base_word = lung_word
                    ^ (cur_word >> shift_cfg.right_shift_amount)
                    ^ (cur_word << shift_cfg.left_shift_amount)
                    ^ lag_word;
   assign mix_word   = base_word ^ (base_word << shift_cfg.feedback_shift);
   assign entry_word = cur_word ^ mix_word ^ (mix_word << shift_cfg.output_shift);

endmodule

>>> hdl/gfsr_lung_random_generator.sv
`timescale 1ns / 1ps

// A one-word item runs through ST_MOD, ST_ADDR, ST_UPD and ST_FIN; a four-word item adds ST_WRD before ST_UPD.
// A new item is accepted only back in ST_IDLE, after the result is loaded; the ring
//   memory has one write and two read ports, and each entry update uses both read ports at once.
// A seed item fills the ring one entry per cycle and gives no result.
// Reset: synchronous, active high; clears position and control, sets all five settings to 1.
//   Ring and lung hold garbage until the first seed item.
module gfsr_lung_random_generator (
   input  logic        clock,
   input  logic        reset,
   gfsr_req_if.sink    req_ch,
   gfsr_rsp_if.source  rsp_ch,
   gfsr_csr_if.sink    csr_ch
);

   localparam int AW = gfsr_pkg::ADDR_W;
   localparam int WW = gfsr_pkg::WORD_W;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SEED = 8'b0000_0010,
      ST_LUNG = 8'b0000_0100,
      ST_MOD  = 8'b0000_1000,
      ST_ADDR = 8'b0001_0000,
      ST_WRD  = 8'b0010_0000,
      ST_UPD  = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // ring storage: one write port, two registered read ports
   logic [WW-1:0] ring_mem [gfsr_pkg::RING_DEPTH];
   logic [WW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   // forwarding of a write that lands on an address read in the same cycle
   logic          fwd_a_ff, fwd_b_ff;
   logic [WW-1:0] fwd_data_ff;

   // settings
   logic [gfsr_pkg::OFF_W-1:0] lag_raw_ff, lag_q_ff;
   gfsr_pkg::shift_cfg_type    shift_cfg_ff;

   // item context
   logic [gfsr_pkg::KIND_W-1:0]  kind_ff;
   logic [gfsr_pkg::COUNT_W-1:0] n_ff;
   logic [gfsr_pkg::OFF_W-1:0]   off_ff, off_q_ff;
   logic [AW-1:0]                offm_ff, lagm_ff;
   logic [WW-1:0]                seed_ff;
   logic [AW-1:0]                cnt_ff;

   // generator state
   logic [WW-1:0] lung_ff;
   logic [AW-1:0] pos_ff;

   // sequencing of ring accesses
   logic [AW-1:0]                cur_addr_ff, lag_addr_ff, word_addr_ff, upd_addr_ff;
   logic                         wcnt_ff;
   logic [gfsr_pkg::COUNT_W-1:0] iss_ff;
   logic                         upd_v_ff, upd_v_in;
   logic                         wrd_v_ff, wsel_ff;
   logic [WW-1:0]                word_ff [gfsr_pkg::WORDS_WIDE];

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   logic [WW-1:0]                rsp_w0_ff, rsp_w1_ff, rsp_w2_ff, rsp_w3_ff;
   logic [gfsr_pkg::COUNT_W-1:0] rsp_count_ff;

   logic          req_fire, csr_fire, issue;
   logic [WW-1:0] cur_val, lag_val, entry_word, mix_word;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // take the forwarded word where the memory returned a stale one
   assign cur_val = fwd_a_ff ? fwd_data_ff : rd_a_ff;
   assign lag_val = fwd_b_ff ? fwd_data_ff : rd_b_ff;

   gfsr_mix u_mix (
      .cur_word   (cur_val),
      .lag_word   (lag_val),
      .lung_word  (lung_ff),
      .shift_cfg  (shift_cfg_ff),
      .entry_word (entry_word),
      .mix_word   (mix_word)
   );

   assign issue    = (state_ff == ST_UPD) && (iss_ff != n_ff);
   assign upd_v_in = issue;
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // read address select: word reads, then update reads
   always_comb begin
      rd_addr_a = cur_addr_ff;
      rd_addr_b = lag_addr_ff;
      if (state_ff == ST_WRD) begin
         rd_addr_a = word_addr_ff;
         rd_addr_b = gfsr_pkg::wrap_add(word_addr_ff, AW'(1));
      end
   end

   // write select: seed fill or an entry update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = upd_addr_ff;
      wr_data = entry_word;
      if (state_ff == ST_SEED) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = seed_ff + WW'(cnt_ff);
      end else if (upd_v_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.kind == gfsr_pkg::KIND_SEED) begin
                  state_in = ST_SEED;
               end else if (req_ch.kind == gfsr_pkg::KIND_ONE ||
                            req_ch.kind == gfsr_pkg::KIND_FOUR) begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_SEED: begin
            if (cnt_ff == AW'(gfsr_pkg::RING_DEPTH - 1)) begin
               state_in = ST_LUNG;
            end
         end
         ST_LUNG: state_in = ST_IDLE;
         ST_MOD:  state_in = ST_ADDR;
         ST_ADDR: state_in = (kind_ff == gfsr_pkg::KIND_FOUR) ? ST_WRD : ST_UPD;
         ST_WRD: begin
            if (wcnt_ff) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (iss_ff == n_ff && upd_v_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= ring_mem[rd_addr_a];
      rd_b_ff <= ring_mem[rd_addr_b];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fwd_a_ff     <= 1'b0;
         fwd_b_ff     <= 1'b0;
         upd_v_ff     <= 1'b0;
         wrd_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         lag_raw_ff   <= gfsr_pkg::OFF_W'(1);
         lag_q_ff     <= gfsr_pkg::quot_ring(gfsr_pkg::OFF_W'(1));
         shift_cfg_ff <= '{feedback_shift:     gfsr_pkg::SHIFT_W'(1),
                           output_shift:       gfsr_pkg::SHIFT_W'(1),
                           right_shift_amount: gfsr_pkg::SHIFT_W'(1),
                           left_shift_amount:  gfsr_pkg::SHIFT_W'(1)};
      end else begin
         state_ff     <= state_in;
         fwd_a_ff     <= wr_en && (wr_addr == rd_addr_a);
         fwd_b_ff     <= wr_en && (wr_addr == rd_addr_b);
         upd_v_ff     <= upd_v_in;
         wrd_v_ff     <= (state_ff == ST_WRD);
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_ch.kind == gfsr_pkg::KIND_SEED) begin
            pos_ff <= '0;
         end else if (rsp_load) begin
            // advance past the entries just updated
            pos_ff <= gfsr_pkg::wrap_add(pos_ff, AW'(n_ff));
         end
         if (csr_fire) begin
            case (csr_ch.index)
               gfsr_pkg::CSR_LAG_OFFSET: begin
                  lag_raw_ff <= csr_ch.data[gfsr_pkg::OFF_W-1:0];
                  lag_q_ff   <= gfsr_pkg::quot_ring(csr_ch.data[gfsr_pkg::OFF_W-1:0]);
               end
               gfsr_pkg::CSR_FEEDBACK:
                  shift_cfg_ff.feedback_shift <= csr_ch.data[gfsr_pkg::SHIFT_W-1:0];
               gfsr_pkg::CSR_OUTPUT:
                  shift_cfg_ff.output_shift <= csr_ch.data[gfsr_pkg::SHIFT_W-1:0];
               gfsr_pkg::CSR_RIGHT_SHIFT:
                  shift_cfg_ff.right_shift_amount <= csr_ch.data[gfsr_pkg::SHIFT_W-1:0];
               gfsr_pkg::CSR_LEFT_SHIFT:
                  shift_cfg_ff.left_shift_amount <= csr_ch.data[gfsr_pkg::SHIFT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;

      if (req_fire) begin
         kind_ff  <= req_ch.kind;
         n_ff     <= (req_ch.kind == gfsr_pkg::KIND_FOUR) ?
                     gfsr_pkg::COUNT_W'(gfsr_pkg::WORDS_WIDE) : gfsr_pkg::COUNT_W'(1);
         off_ff   <= req_ch.read_offset;
         off_q_ff <= gfsr_pkg::quot_ring(req_ch.read_offset);
         seed_ff  <= req_ch.seed_value;
         cnt_ff   <= '0;
      end

      case (state_ff)
         ST_SEED: begin
            seed_ff <= seed_ff * gfsr_pkg::SEED_MULT;
            cnt_ff  <= cnt_ff + AW'(1);
         end
         ST_LUNG: lung_ff <= seed_ff + WW'(gfsr_pkg::RING_DEPTH);
         ST_MOD: begin
            offm_ff <= gfsr_pkg::rem_ring(off_ff, off_q_ff);
            lagm_ff <= gfsr_pkg::rem_ring(lag_raw_ff, lag_q_ff);
         end
         ST_ADDR: begin
            cur_addr_ff  <= pos_ff;
            lag_addr_ff  <= gfsr_pkg::wrap_add(pos_ff, lagm_ff);
            word_addr_ff <= gfsr_pkg::wrap_add(pos_ff, offm_ff);
            wcnt_ff      <= 1'b0;
            iss_ff       <= '0;
         end
         ST_WRD: begin
            word_addr_ff <= gfsr_pkg::wrap_add(word_addr_ff, AW'(2));
            wcnt_ff      <= 1'b1;
         end
         default: ;
      endcase

      wsel_ff <= wcnt_ff;

      // issue the reads of the next entry and its lagged partner
      if (issue) begin
         upd_addr_ff <= cur_addr_ff;
         cur_addr_ff <= gfsr_pkg::wrap_add(cur_addr_ff, AW'(1));
         lag_addr_ff <= gfsr_pkg::wrap_add(lag_addr_ff, AW'(1));
         iss_ff      <= iss_ff + gfsr_pkg::COUNT_W'(1);
      end

      // capture the words handed out by a four-word item
      if (wrd_v_ff) begin
         word_ff[{wsel_ff, 1'b0}] <= rd_a_ff;
         word_ff[{wsel_ff, 1'b1}] <= rd_b_ff;
      end

      // entry update: the lung follows the mixing word
      if (upd_v_ff) begin
         lung_ff <= mix_word;
         if (kind_ff == gfsr_pkg::KIND_ONE && iss_ff == gfsr_pkg::COUNT_W'(1)) begin
            word_ff[0] <= cur_val;
         end
      end

      if (rsp_load) begin
         rsp_w0_ff    <= word_ff[0];
         rsp_w1_ff    <= (kind_ff == gfsr_pkg::KIND_FOUR) ? word_ff[1] : '0;
         rsp_w2_ff    <= (kind_ff == gfsr_pkg::KIND_FOUR) ? word_ff[2] : '0;
         rsp_w3_ff    <= (kind_ff == gfsr_pkg::KIND_FOUR) ? word_ff[3] : '0;
         rsp_count_ff <= n_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.word0      = rsp_w0_ff;
   assign rsp_ch.word1      = rsp_w1_ff;
   assign rsp_ch.word2      = rsp_w2_ff;
   assign rsp_ch.word3      = rsp_w3_ff;
   assign rsp_ch.word_count = rsp_count_ff;

endmodule
